>>> rtl/trvm_pkg.sv
`default_nettype none

package trvm_pkg;

  localparam int REG_COUNT  = 4;
  localparam int DATA_WORDS = 256;
  localparam int PROG_WORDS = 1024;

  localparam int FUNC_W    = 4;
  localparam int OPA_W     = 10;
  localparam int WORD_W    = 32;
  localparam int PC_W      = $clog2(PROG_WORDS);
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int MEM_IDX_W = $clog2(DATA_WORDS);

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_LOAD  = 4'd2,
    OP_STW   = 4'd3,
    OP_MOV   = 4'd4,
    OP_MOVI  = 4'd5,
    OP_XOR   = 4'd6,
    OP_AND   = 4'd7,
    OP_OR    = 4'd8,
    OP_OUT   = 4'd9,
    OP_IN    = 4'd10,
    OP_JMP   = 4'd11,
    OP_JZ    = 4'd12,
    OP_HALT  = 4'd13
  } op_t;

  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_XOR,
    ALU_AND,
    ALU_OR,
    ALU_PASS_B,
    ALU_IMM,
    ALU_IN
  } alu_t;

  typedef struct packed {
    logic                 wr_reg;
    logic                 is_load;
    logic                 is_store;
    logic                 is_out;
    logic                 is_jmp;
    logic                 is_jz;
    logic                 is_halt;
    alu_t                 alu;
    logic [REG_IDX_W-1:0] ra;
    logic [REG_IDX_W-1:0] rb;
    logic [MEM_IDX_W-1:0] load_addr;
    logic [MEM_IDX_W-1:0] store_addr;
    logic [PC_W-1:0]      target;
    logic [WORD_W-1:0]    imm;
    logic [WORD_W-1:0]    in_word;
  } uop_t;

  typedef struct packed {
    logic valid;
    uop_t uop;
  } queue_head_t;

endpackage

`default_nettype wire

>>> rtl/trvm_if.sv
`default_nettype none

interface trvm_instr_if;
  logic                          valid;
  logic                          ready;
  logic [trvm_pkg::FUNC_W-1:0]   func;
  logic [trvm_pkg::OPA_W-1:0]    operand_a;
  logic [trvm_pkg::WORD_W-1:0]   operand_b;
  logic [trvm_pkg::WORD_W-1:0]   in_word;

  modport source(output valid, output func, output operand_a, output operand_b,
                 output in_word, input ready);
  modport sink(input valid, input func, input operand_a, input operand_b,
               input in_word, output ready);
endinterface

interface trvm_result_if;
  logic                          valid;
  logic                          ready;
  logic [trvm_pkg::PC_W-1:0]     next_pc;
  logic                          out_valid;
  logic [trvm_pkg::WORD_W-1:0]   out_word;
  logic                          halted;

  modport source(output valid, output next_pc, output out_valid, output out_word,
                 output halted, input ready);
  modport sink(input valid, input next_pc, input out_valid, input out_word,
               input halted, output ready);
endinterface

`default_nettype wire

>>> rtl/tiny_register_vm_execute.sv
// Execution unit of a small register machine with four 32-bit registers and
// 256 data words. Each item on the instr channel is one fetched instruction
// (opcode, two operands and the word from the input device); each item on the
// result channel gives the next fetch address, an optional output word and the
// halted flag. Exactly one result follows every instruction, in order.
// An instruction passes through a decoder and a two-entry queue, then the
// execute stage, which writes the result register. An accepted instruction is
// written into the queue, and its result is offered from the result register
// once execute has taken it. One instruction per cycle is sustained while the
// receiver holds ready high; a load writes its register in the cycle after
// execute, and its value is forwarded to the next instruction without a stall.
// When the receiver holds ready low, the result register holds its item, the
// execute stage stops and the queue fills; instr.ready drops once both queue
// entries are taken, and nothing is lost.
// Reset clears the registers, the program counter, the halt flag, the queue and
// the written flags of the data memory, so every data word reads as zero until
// stored. The block takes instructions in the first cycle after reset.
// After a halt every later instruction is answered with the held address and
// the halted flag set, and changes nothing.
`default_nettype none

module tiny_register_vm_execute (
  input wire            clk,
  input wire            rst,
  trvm_instr_if.sink    instr,
  trvm_result_if.source result
);

  trvm_pkg::queue_head_t head;
  logic                  pop;

  trvm_front u_front (
    .clk   (clk),
    .rst   (rst),
    .instr (instr),
    .head  (head),
    .pop   (pop)
  );

  trvm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

>>> rtl/trvm_front.sv
`default_nettype none

module trvm_front (
  input  wire                   clk,
  input  wire                   rst,
  trvm_instr_if.sink            instr,
  output trvm_pkg::queue_head_t head,
  input  wire                   pop
);

  trvm_pkg::uop_t uop;
  trvm_pkg::uop_t slot [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;
  logic           push;

  always_comb begin
    uop            = '0;
    uop.alu        = trvm_pkg::ALU_ADD;
    uop.ra         = instr.operand_a[trvm_pkg::REG_IDX_W-1:0];
    uop.rb         = instr.operand_b[trvm_pkg::REG_IDX_W-1:0];
    uop.load_addr  = instr.operand_b[trvm_pkg::MEM_IDX_W-1:0];
    uop.store_addr = instr.operand_a[trvm_pkg::MEM_IDX_W-1:0];
    uop.target     = instr.operand_a[trvm_pkg::PC_W-1:0];
    uop.imm        = instr.operand_b;
    uop.in_word    = instr.in_word;
    unique case (trvm_pkg::op_t'(instr.func))
      trvm_pkg::OP_ADD: begin
        uop.wr_reg = 1'b1;
        uop.alu    = trvm_pkg::ALU_ADD;
      end
      trvm_pkg::OP_SUB: begin
        uop.wr_reg = 1'b1;
        uop.alu    = trvm_pkg::ALU_SUB;
      end
      trvm_pkg::OP_LOAD:  uop.is_load = 1'b1;
      trvm_pkg::OP_STW:   uop.is_store = 1'b1;
      trvm_pkg::OP_MOV: begin
        uop.wr_reg = 1'b1;
        uop.alu    = trvm_pkg::ALU_PASS_B;
      end
      trvm_pkg::OP_MOVI: begin
        uop.wr_reg = 1'b1;
        uop.alu    = trvm_pkg::ALU_IMM;
      end
      trvm_pkg::OP_XOR: begin
        uop.wr_reg = 1'b1;
        uop.alu    = trvm_pkg::ALU_XOR;
      end
      trvm_pkg::OP_AND: begin
        uop.wr_reg = 1'b1;
        uop.alu    = trvm_pkg::ALU_AND;
      end
      trvm_pkg::OP_OR: begin
        uop.wr_reg = 1'b1;
        uop.alu    = trvm_pkg::ALU_OR;
      end
      trvm_pkg::OP_OUT: uop.is_out = 1'b1;
      trvm_pkg::OP_IN: begin
        uop.wr_reg = 1'b1;
        uop.alu    = trvm_pkg::ALU_IN;
      end
      trvm_pkg::OP_JMP:  uop.is_jmp = 1'b1;
      trvm_pkg::OP_JZ:   uop.is_jz = 1'b1;
      trvm_pkg::OP_HALT: uop.is_halt = 1'b1;
      default: ;
    endcase
  end

  assign instr.ready = (count != 2'd2);
  assign push        = instr.valid && instr.ready;
  assign head.valid  = (count != 2'd0);
  assign head.uop    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= uop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/trvm_back.sv
`default_nettype none

module trvm_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire trvm_pkg::queue_head_t head,
  output logic                  pop,
  trvm_result_if.source         result
);

  logic [trvm_pkg::WORD_W-1:0]    rf [trvm_pkg::REG_COUNT];
  logic [trvm_pkg::WORD_W-1:0]    mem [trvm_pkg::DATA_WORDS];
  logic [trvm_pkg::DATA_WORDS-1:0] mem_written;
  logic [trvm_pkg::WORD_W-1:0]    mem_q;
  logic                           mem_q_written;

  logic                           wb_valid;
  logic [trvm_pkg::REG_IDX_W-1:0] wb_rd;
  logic [trvm_pkg::WORD_W-1:0]    wb_data;

  logic [trvm_pkg::PC_W-1:0]      pc;
  logic [trvm_pkg::PC_W-1:0]      pc_next;
  logic                           halt_flag;
  logic                           halt_next;

  logic                           res_valid;
  logic [trvm_pkg::PC_W-1:0]      res_pc;
  logic                           res_out_valid;
  logic [trvm_pkg::WORD_W-1:0]    res_out_word;
  logic                           res_halted;

  trvm_pkg::uop_t                 u;
  logic                           live;
  logic [trvm_pkg::WORD_W-1:0]    val_a;
  logic [trvm_pkg::WORD_W-1:0]    val_b;
  logic [trvm_pkg::WORD_W-1:0]    alu_out;
  logic [trvm_pkg::PC_W-1:0]      pc_base;

  assign u       = head.uop;
  assign pop     = head.valid && (!res_valid || result.ready);
  assign live    = pop && !halt_flag;
  assign wb_data = mem_q_written ? mem_q : '0;

  // A load still in writeback is forwarded to the instruction behind it.
  always_comb begin
    val_a = (wb_valid && wb_rd == u.ra) ? wb_data : rf[u.ra];
    val_b = (wb_valid && wb_rd == u.rb) ? wb_data : rf[u.rb];
  end

  always_comb begin
    unique case (u.alu)
      trvm_pkg::ALU_ADD:    alu_out = val_a + val_b;
      trvm_pkg::ALU_SUB:    alu_out = val_a - val_b;
      trvm_pkg::ALU_XOR:    alu_out = val_a ^ val_b;
      trvm_pkg::ALU_AND:    alu_out = val_a & val_b;
      trvm_pkg::ALU_OR:     alu_out = val_a | val_b;
      trvm_pkg::ALU_PASS_B: alu_out = val_b;
      trvm_pkg::ALU_IMM:    alu_out = u.imm;
      trvm_pkg::ALU_IN:     alu_out = u.in_word;
      default:              alu_out = '0;
    endcase
  end

  always_comb begin
    halt_next = halt_flag;
    pc_next   = pc;
    pc_base   = pc;
    if (!halt_flag) begin
      if (u.is_jmp || (u.is_jz && val_b == '0)) begin
        pc_base = u.target;
      end
      if (u.is_halt) begin
        halt_next = 1'b1;
      end else begin
        pc_next = pc_base + trvm_pkg::PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (live && u.is_store) begin
      mem[u.store_addr] <= val_b;
    end
    if (live && u.is_load) begin
      mem_q <= mem[u.load_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_written   <= '0;
      mem_q_written <= 1'b0;
      wb_valid      <= 1'b0;
      wb_rd         <= '0;
      pc            <= '0;
      halt_flag     <= 1'b0;
      res_valid     <= 1'b0;
      for (int i = 0; i < trvm_pkg::REG_COUNT; i++) begin
        rf[i] <= '0;
      end
    end else begin
      wb_valid <= live && u.is_load;
      if (live && u.is_load) begin
        wb_rd         <= u.ra;
        mem_q_written <= mem_written[u.load_addr];
      end
      if (live && u.is_store) begin
        mem_written[u.store_addr] <= 1'b1;
      end
      // The older load writes first, so a younger write to the same register wins.
      if (wb_valid) begin
        rf[wb_rd] <= wb_data;
      end
      if (live && u.wr_reg) begin
        rf[u.ra] <= alu_out;
      end
      if (pop) begin
        pc        <= pc_next;
        halt_flag <= halt_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_pc        <= pc_next;
      res_out_valid <= live && u.is_out;
      res_out_word  <= (live && u.is_out) ? val_a : '0;
      res_halted    <= halt_next;
    end
  end

  assign result.valid     = res_valid;
  assign result.next_pc   = res_pc;
  assign result.out_valid = res_out_valid;
  assign result.out_word  = res_out_word;
  assign result.halted    = res_halted;

endmodule

`default_nettype wire

>>> rtl/trvm_chk.sv
`default_nettype none

module trvm_chk (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          res_valid,
  input wire                          res_ready,
  input wire [trvm_pkg::PC_W-1:0]     res_next_pc,
  input wire                          res_out_valid,
  input wire [trvm_pkg::WORD_W-1:0]   res_out_word,
  input wire                          res_halted
);

  logic                      seen_halt;
  logic [trvm_pkg::PC_W-1:0] halt_pc;
  logic [2:0]                pending;
  logic                      in_acc;
  logic                      res_acc;

  assign in_acc  = in_valid && in_ready;
  assign res_acc = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
      halt_pc   <= '0;
      pending   <= '0;
    end else begin
      if (res_acc && res_halted && !seen_halt) begin
        seen_halt <= 1'b1;
        halt_pc   <= res_next_pc;
      end
      if (in_acc && !res_acc) begin
        pending <= pending + 3'd1;
      end else if (res_acc && !in_acc) begin
        pending <= pending - 3'd1;
      end
    end
  end

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (pending != 3'd0))
    else $error("Result offered with no instruction outstanding.");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (res_acc && seen_halt) |-> (res_halted && !res_out_valid && res_next_pc == halt_pc))
    else $error("Result after halt changed the machine state.");

  a_quiet_word: assert property (@(posedge clk) disable iff (rst)
    (res_acc && !res_out_valid) |-> (res_out_word == '0))
    else $error("Output word is not zero without an output.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_next_pc)
      && $stable(res_out_word) && $stable(res_halted)))
    else $error("Stalled result changed.");

endmodule

bind tiny_register_vm_execute trvm_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (instr.valid),
  .in_ready      (instr.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_next_pc   (result.next_pc),
  .res_out_valid (result.out_valid),
  .res_out_word  (result.out_word),
  .res_halted    (result.halted)
);

`default_nettype wire
